>>> rtl/core/twk_pkg.sv
// Shared constants, types and codes for the timed wakeup slot block.
package twk_pkg;

    localparam int SLOTS        = 8;
    localparam int SLOT_IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DELAY_BITS   = 16;
    localparam int EVENT_W      = 16;
    localparam int DELAY_IN_W   = 16;

    localparam int MAX_RESULTS  = 8;
    localparam int RES_IDX_W    = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

    localparam int TPS_W        = 6;
    localparam logic [TPS_W-1:0] TPS_RESET = 6'd60;

    localparam int SEC_W        = 6;
    localparam int MIN_W        = 6;
    localparam int HOUR_W       = 7;
    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_LAST = 7'd99;

    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 40;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_ENQUEUE = 1'b1;

    typedef enum logic [2:0] {
        SLOT_NOP,
        SLOT_FILL,
        SLOT_DEC,
        SLOT_FREE,
        SLOT_RETRY
    } slot_op_t;

    typedef struct packed {
        slot_op_t                op;
        logic [SLOT_IDX_W-1:0]   idx;
        logic [EVENT_W-1:0]      event_id;
        logic [DELAY_BITS-1:0]   delay;
    } slot_cmd_t;

    typedef struct packed {
        logic                    busy;
        logic [EVENT_W-1:0]      event_id;
        logic                    dec_zero;
    } slot_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ_SCAN,
        ST_TICK_SCAN,
        ST_EMIT
    } seq_state_t;

endpackage

>>> rtl/core/timed_wakeup_slots_with_clock.sv
// Top level: item sequencer, wakeup result buffer and output register.
//
// Usage: items enter on the s_axis channel. tuser selects a tick (0) or an enqueue (1);
// tdata carries the delay in seconds and the event id. Every item yields one or more
// result items on m_axis: an enqueue gives one result telling whether a slot was taken;
// a tick gives one result per event that expired on it, in slot order, or a single
// empty result if none did. tlast marks the final result of each input item, and every
// result shows the clock as it stands after that item. The user writes ticks_per_second
// through cfg_wr_en / cfg_wr_data only while the block is idle; nothing enforces this.
// Timing: the sequencer walks the slot table one slot per cycle through one shared
// decrement-and-compare unit. An enqueue scans up to the first free slot, then loads
// its result; an enqueue with event 0 and a tick that does not complete a second go
// straight to the result. A tick that completes a second scans all 8 slots, then loads
// one result per cycle while the output register can take it. s_tready is high only
// between items.
// Reset: all slots free, clock 00:00:00, prescaler at zero, ticks_per_second = 60.
// Stalls: results wait in the output register while m_tready is low; the next input
// item may be accepted while the final result of the previous one still waits there.
module timed_wakeup_slots_with_clock (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [twk_pkg::TPS_W-1:0]           cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: delay_seconds [15:0], event_id [31:16]
    input  logic [twk_pkg::IN_DATA_W-1:0]       s_tdata,
    // tuser: kind [0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: wake_event [15:0], accepted [16], clock_hours [23:17],
    // clock_minutes [29:24], clock_seconds [35:30], zero [39:36]
    output logic [twk_pkg::OUT_DATA_W-1:0]      m_tdata,
    // tuser: wake_valid [0]
    output logic                                m_tuser,
    output logic                                m_tlast
);

    twk_pkg::seq_state_t               state_reg, state_next;
    logic [twk_pkg::SLOT_IDX_W-1:0]    idx_reg, idx_next;
    logic [twk_pkg::RES_CNT_W-1:0]     n_reg, n_next;
    logic [twk_pkg::RES_IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic                              acc_reg, acc_next;
    logic [twk_pkg::EVENT_W-1:0]       ev_reg;
    logic [twk_pkg::DELAY_BITS-1:0]    delay_reg;
    logic [twk_pkg::EVENT_W-1:0]       woke_reg [twk_pkg::MAX_RESULTS];
    logic                              woke_we;

    logic                              m_tvalid_reg;
    logic [twk_pkg::OUT_DATA_W-1:0]    m_tdata_reg;
    logic                              m_tuser_reg;
    logic                              m_tlast_reg;
    logic                              out_load;
    logic                              out_free;
    logic                              out_last;
    logic                              out_wake;
    logic [twk_pkg::EVENT_W-1:0]       out_event;

    logic                              in_accept;
    logic                              is_tick;
    logic                              sec_done;
    logic [twk_pkg::HOUR_W-1:0]        hours;
    logic [twk_pkg::MIN_W-1:0]         minutes;
    logic [twk_pkg::SEC_W-1:0]         seconds;
    logic [twk_pkg::EVENT_W-1:0]       in_event;
    logic [twk_pkg::DELAY_IN_W-1:0]    in_delay;
    logic                              last_slot;

    twk_pkg::slot_cmd_t                slot_cmd;
    twk_pkg::slot_stat_t               slot_stat;

    assign s_tready  = (state_reg == twk_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign is_tick   = (s_tuser == twk_pkg::KIND_TICK);
    assign in_delay  = s_tdata[twk_pkg::DELAY_IN_W-1:0];
    assign in_event  = s_tdata[twk_pkg::DELAY_IN_W +: twk_pkg::EVENT_W];
    assign last_slot = (idx_reg == twk_pkg::SLOT_IDX_W'(twk_pkg::SLOTS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    twk_rtc u_rtc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (in_accept && is_tick),
        .sec_done    (sec_done),
        .hours       (hours),
        .minutes     (minutes),
        .seconds     (seconds)
    );

    twk_slot_table u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (slot_cmd),
        .stat  (slot_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= twk_pkg::ST_IDLE;
            idx_reg     <= '0;
            n_reg       <= '0;
            out_idx_reg <= '0;
            acc_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            out_idx_reg <= out_idx_next;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ev_reg    <= in_event;
            delay_reg <= twk_pkg::DELAY_BITS'(in_delay);
        end
        if (woke_we)
        begin
            woke_reg[n_reg[twk_pkg::RES_IDX_W-1:0]] <= slot_stat.event_id;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        out_idx_next     = out_idx_reg;
        acc_next         = acc_reg;
        woke_we          = 1'b0;
        out_load         = 1'b0;
        slot_cmd.op      = twk_pkg::SLOT_NOP;
        slot_cmd.idx     = idx_reg;
        slot_cmd.event_id = ev_reg;
        // A zero delay is stored as one second.
        slot_cmd.delay   = (delay_reg == '0) ? twk_pkg::DELAY_BITS'(1) : delay_reg;

        out_last  = (n_reg == '0) ||
                    (twk_pkg::RES_CNT_W'(out_idx_reg) == n_reg - twk_pkg::RES_CNT_W'(1));
        out_wake  = (n_reg != '0);
        out_event = out_wake ? woke_reg[out_idx_reg] : '0;

        unique case (state_reg)
            twk_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next     = '0;
                    n_next       = '0;
                    out_idx_next = '0;
                    acc_next     = 1'b0;
                    if (!is_tick)
                    begin
                        state_next = (in_event == '0) ? twk_pkg::ST_EMIT :
                                                        twk_pkg::ST_ENQ_SCAN;
                    end
                    else
                    begin
                        state_next = sec_done ? twk_pkg::ST_TICK_SCAN : twk_pkg::ST_EMIT;
                    end
                end
            end
            twk_pkg::ST_ENQ_SCAN:
            begin
                if (!slot_stat.busy)
                begin
                    slot_cmd.op = twk_pkg::SLOT_FILL;
                    acc_next    = 1'b1;
                    state_next  = twk_pkg::ST_EMIT;
                end
                else if (last_slot)
                begin
                    state_next = twk_pkg::ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + twk_pkg::SLOT_IDX_W'(1);
                end
            end
            twk_pkg::ST_TICK_SCAN:
            begin
                if (slot_stat.busy)
                begin
                    if (!slot_stat.dec_zero)
                    begin
                        slot_cmd.op = twk_pkg::SLOT_DEC;
                    end
                    else if (n_reg < twk_pkg::RES_CNT_W'(twk_pkg::MAX_RESULTS))
                    begin
                        slot_cmd.op = twk_pkg::SLOT_FREE;
                        woke_we     = 1'b1;
                        n_next      = n_reg + twk_pkg::RES_CNT_W'(1);
                    end
                    else
                    begin
                        // Result buffer is full: this slot expires at the next second.
                        slot_cmd.op = twk_pkg::SLOT_RETRY;
                    end
                end
                if (last_slot)
                begin
                    state_next = twk_pkg::ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + twk_pkg::SLOT_IDX_W'(1);
                end
            end
            twk_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (out_last)
                    begin
                        state_next   = twk_pkg::ST_IDLE;
                        out_idx_next = '0;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + twk_pkg::RES_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = twk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {4'b0000, seconds, minutes, hours, acc_reg, out_event};
            m_tuser_reg <= out_wake;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/core/twk_slot_table.sv
// Slot table with the shared decrement-and-compare unit that serves one slot per cycle.
module twk_slot_table (
    input  logic                clk,
    input  logic                rst_n,
    input  twk_pkg::slot_cmd_t  cmd,
    output twk_pkg::slot_stat_t stat
);

    logic [twk_pkg::EVENT_W-1:0]    slot_event_reg [twk_pkg::SLOTS];
    logic [twk_pkg::DELAY_BITS-1:0] slot_remaining_reg [twk_pkg::SLOTS];
    logic [twk_pkg::DELAY_BITS-1:0] rem_dec;

    // The one decrementer in the block; it works on the slot the sequencer points at.
    assign rem_dec = slot_remaining_reg[cmd.idx] - twk_pkg::DELAY_BITS'(1);

    assign stat.event_id = slot_event_reg[cmd.idx];
    assign stat.busy     = (slot_event_reg[cmd.idx] != '0);
    assign stat.dec_zero = (rem_dec == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < twk_pkg::SLOTS; i++)
            begin
                slot_event_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (cmd.op)
                twk_pkg::SLOT_FILL: slot_event_reg[cmd.idx] <= cmd.event_id;
                twk_pkg::SLOT_FREE: slot_event_reg[cmd.idx] <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            twk_pkg::SLOT_FILL:  slot_remaining_reg[cmd.idx] <= cmd.delay;
            twk_pkg::SLOT_DEC:   slot_remaining_reg[cmd.idx] <= rem_dec;
            twk_pkg::SLOT_RETRY: slot_remaining_reg[cmd.idx] <= twk_pkg::DELAY_BITS'(1);
            default: ;
        endcase
    end

endmodule

>>> rtl/core/twk_rtc.sv
// Tick prescaler and the seconds, minutes and hours counters of the time-of-day clock.
module twk_rtc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [twk_pkg::TPS_W-1:0]  cfg_wr_data,
    input  logic                       tick,
    output logic                       sec_done,
    output logic [twk_pkg::HOUR_W-1:0] hours,
    output logic [twk_pkg::MIN_W-1:0]  minutes,
    output logic [twk_pkg::SEC_W-1:0]  seconds
);

    logic [twk_pkg::TPS_W-1:0]  tps_reg;
    logic [twk_pkg::TPS_W-1:0]  tick_count_reg;
    logic [twk_pkg::TPS_W-1:0]  tick_count_next;
    logic [twk_pkg::SEC_W-1:0]  sec_reg;
    logic [twk_pkg::MIN_W-1:0]  min_reg;
    logic [twk_pkg::HOUR_W-1:0] hour_reg;

    // A setting of zero compares true on every tick, so it acts like one.
    assign tick_count_next = tick_count_reg + twk_pkg::TPS_W'(1);
    assign sec_done        = tick && (tick_count_next >= tps_reg);

    assign hours   = hour_reg;
    assign minutes = min_reg;
    assign seconds = sec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= twk_pkg::TPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            tps_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
        end
        else if (tick)
        begin
            if (!sec_done)
            begin
                tick_count_reg <= tick_count_next;
            end
            else
            begin
                tick_count_reg <= '0;
                if (sec_reg != twk_pkg::SEC_LAST)
                begin
                    sec_reg <= sec_reg + twk_pkg::SEC_W'(1);
                end
                else
                begin
                    sec_reg <= '0;
                    if (min_reg != twk_pkg::MIN_LAST)
                    begin
                        min_reg <= min_reg + twk_pkg::MIN_W'(1);
                    end
                    else
                    begin
                        min_reg  <= '0;
                        hour_reg <= (hour_reg == twk_pkg::HOUR_LAST) ? '0 :
                                    hour_reg + twk_pkg::HOUR_W'(1);
                    end
                end
            end
        end
    end

endmodule
